// ----- src/r64d_pkg.sv -----
package r64d_pkg;

   // character codes that are skipped
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   // alphabet anchors and symbol offsets
   localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_UNDER   = 8'h5F;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

   localparam logic [5:0] SYM_DOLLAR  = 6'd0;
   localparam logic [5:0] SYM_DIGIT0  = 6'd1;
   localparam logic [5:0] SYM_UPPER_A = 6'd11;
   localparam logic [5:0] SYM_UNDER   = 6'd37;
   localparam logic [5:0] SYM_LOWER_A = 6'd38;

   // accumulator geometry
   localparam int ACC_BITS  = 14;
   localparam int HELD_BITS = 4;
   localparam logic [HELD_BITS-1:0] SYM_BITS  = 4'd6;
   localparam logic [HELD_BITS-1:0] BYTE_BITS = 4'd8;

   // result item layout
   localparam int RSP_DATA_BITS = 32;

   // classification of one character
   typedef struct packed {
      logic       is_space;
      logic       is_symbol;
      logic [5:0] value;
   } char_class_type;

endpackage

// ----- src/r64d_char_map.sv -----
module r64d_char_map (
   input  logic [7:0]               char_code,
   output r64d_pkg::char_class_type char_class
);
   import r64d_pkg::*;

   // whitespace test and alphabet lookup
   always_comb begin
      char_class          = '0;
      char_class.is_space = (char_code == CHAR_SPACE) || (char_code == CHAR_TAB) ||
                            (char_code == CHAR_CR) || (char_code == CHAR_LF);
      if (char_code == CHAR_DOLLAR) begin
         char_class.is_symbol = 1'b1;
         char_class.value     = SYM_DOLLAR;
      end else if (char_code inside {[CHAR_ZERO:CHAR_NINE]}) begin
         char_class.is_symbol = 1'b1;
         char_class.value     = 6'(char_code - CHAR_ZERO) + SYM_DIGIT0;
      end else if (char_code inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
         char_class.is_symbol = 1'b1;
         char_class.value     = 6'(char_code - CHAR_UPPER_A) + SYM_UPPER_A;
      end else if (char_code == CHAR_UNDER) begin
         char_class.is_symbol = 1'b1;
         char_class.value     = SYM_UNDER;
      end else if (char_code inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
         char_class.is_symbol = 1'b1;
         char_class.value     = 6'(char_code - CHAR_LOWER_A) + SYM_LOWER_A;
      end
   end

endmodule

// ----- src/radix64_text_decoder_core.sv -----
// Radix-64 text decoder: one character byte in per item, decoded bytes out.
// Input channel req_*: tdata carries the character, tlast marks the final
// character of a text. Space, tab, CR and LF are skipped; any other character
// outside the alphabet sets the error flag and stops decoding until tlast.
// Result channel rsp_*: one item per decoded byte and one closing item per text
// (tlast high) that carries the error flag and the saturating byte count; a
// byte decoded from the final character shares the closing item.
// The result passes through the input register and then the result register.
// Throughput: one character per cycle while the receiver takes results, set by
// the combinational accumulator update between the two registers.
// The receiver may stall freely: while rsp_tready is low one item waits in
// each register, including characters that give no result, so req_tready
// drops only when both are full.
// Reset clears the accumulator, the counters, the error flag and both valid
// flags; after a closing item the state returns to the same reset values.
module radix64_text_decoder_core #(
   parameter int COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // input item
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tlast,   // last_char
   // result item
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [r64d_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
                                    // [7:0] data_byte, [8] bad_char,
                                    // [24:9] byte_count, [31:25] zero
   output logic        rsp_tuser,   // byte_valid
   output logic        rsp_tlast    // end_of_text
);
   import r64d_pkg::*;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff;
   logic       in_last_ff;

   // decoder state
   logic [ACC_BITS-1:0]   acc_ff, acc_in;
   logic [HELD_BITS-1:0]  held_ff, held_in;
   logic                  err_ff, err_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   // result register
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_byte_ff;
   logic        out_byte_valid_ff;
   logic        out_end_ff;
   logic        out_bad_ff;
   logic [15:0] out_count_ff;

   char_class_type        char_class;
   logic                  advance;
   logic                  decode_en;
   logic [ACC_BITS-1:0]   acc_sum;
   logic [HELD_BITS-1:0]  held_sum;
   logic                  have_byte;
   logic                  emit;

   r64d_char_map u_char_map (
      .char_code  (in_char_ff),
      .char_class (char_class)
   );

   // handshake
   assign advance     = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);

   // accumulator update for the registered character
   assign decode_en = !err_ff && !char_class.is_space && char_class.is_symbol;
   assign acc_sum   = acc_ff | (ACC_BITS'(char_class.value) << held_ff);
   assign held_sum  = held_ff + SYM_BITS;
   assign have_byte = decode_en && (held_sum >= BYTE_BITS);
   assign emit      = have_byte || in_last_ff;

   // next state
   always_comb begin
      acc_in   = acc_ff;
      held_in  = held_ff;
      err_in   = err_ff;
      count_in = count_ff;
      if (advance) begin
         if (!err_ff && !char_class.is_space && !char_class.is_symbol) begin
            err_in = 1'b1;
         end
         if (decode_en) begin
            if (have_byte) begin
               acc_in  = acc_sum >> 8;
               held_in = held_sum - BYTE_BITS;
               if (count_ff != COUNT_MAX) begin
                  count_in = count_ff + 1'b1;
               end
            end else begin
               acc_in  = acc_sum;
               held_in = held_sum;
            end
         end
      end
   end

   // result valid
   assign out_valid_in = (advance && emit) || (out_valid_ff && !rsp_tready);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         acc_ff       <= '0;
         held_ff      <= '0;
         err_ff       <= 1'b0;
         count_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance && in_last_ff) begin
            acc_ff   <= '0;
            held_ff  <= '0;
            err_ff   <= 1'b0;
            count_ff <= '0;
         end else begin
            acc_ff   <= acc_in;
            held_ff  <= held_in;
            err_ff   <= err_in;
            count_ff <= count_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance && emit) begin
         out_byte_ff       <= have_byte ? acc_sum[7:0] : 8'h00;
         out_byte_valid_ff <= have_byte;
         out_end_ff        <= in_last_ff;
         out_bad_ff        <= err_in;
         out_count_ff      <= 16'(count_in);
      end
   end

   // result ports
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'b0, out_count_ff, out_bad_ff, out_byte_ff};
   assign rsp_tuser  = out_byte_valid_ff;
   assign rsp_tlast  = out_end_ff;

endmodule

// ----- tb/radix64_text_decoder_core_tb.sv -----
module radix64_text_decoder_core_tb;
   import r64d_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_LEN    = 300;
   localparam int COUNT_TOP   = 65535;

   // one character as queued for the driver
   typedef struct {
      logic [7:0] code;
      logic       last;
      int         gap;
      bit         steady;
      bit         drain;
      bit         hold;
   } char_item_type;

   // one decoded result in port order
   typedef struct packed {
      logic [7:0]  data_byte;
      logic        byte_valid;
      logic        end_of_text;
      logic        bad_char;
      logic [15:0] byte_count;
   } text_result_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   char_item_type   pending_q[$];
   text_result_type expected_out_q[$];

   // decoder state as predicted
   logic [13:0] dec_acc   = '0;
   logic [3:0]  dec_held  = '0;
   logic        dec_err   = 1'b0;
   int          dec_count = 0;

   int   fail_count   = 0;
   int   cycle_count  = 0;
   int   send_gap     = 0;
   int   recv_wait    = 0;
   int   hold_cycles  = 0;
   int   calm_left    = 0;
   int   items_queued = 0;
   bit   hold_next    = 1'b0;
   logic rx_steady    = 1'b0;
   logic rx_hold      = 1'b0;
   logic hold_req     = 1'b0;

   radix64_text_decoder_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // expected result of one accepted character, state updated in place
   task automatic decode_char(input logic [7:0] code, input logic last);
      logic        sym_ok;
      logic [7:0]  base;
      logic [7:0]  diff;
      logic [5:0]  first;
      logic [5:0]  sym;
      logic [31:0] wide;
      logic [3:0]  held;
      logic        got;
      logic [7:0]  dbyte;
      sym_ok = 1'b1;
      base   = CHAR_DOLLAR;
      first  = SYM_DOLLAR;
      got    = 1'b0;
      dbyte  = '0;
      if (code == CHAR_DOLLAR) begin
         base = CHAR_DOLLAR; first = SYM_DOLLAR;
      end else if (code >= CHAR_ZERO && code <= CHAR_NINE) begin
         base = CHAR_ZERO; first = SYM_DIGIT0;
      end else if (code >= CHAR_UPPER_A && code <= CHAR_UPPER_Z) begin
         base = CHAR_UPPER_A; first = SYM_UPPER_A;
      end else if (code == CHAR_UNDER) begin
         base = CHAR_UNDER; first = SYM_UNDER;
      end else if (code >= CHAR_LOWER_A && code <= CHAR_LOWER_Z) begin
         base = CHAR_LOWER_A; first = SYM_LOWER_A;
      end else begin
         sym_ok = 1'b0;
      end
      diff = code - base;
      sym  = diff[5:0] + first;

      // blanks are skipped, nothing is decoded once an error is seen
      if (!dec_err && code != CHAR_SPACE && code != CHAR_TAB && code != CHAR_CR &&
          code != CHAR_LF) begin
         if (!sym_ok) begin
            dec_err = 1'b1;
         end else begin
            wide    = {18'd0, dec_acc} | ({26'd0, sym} << dec_held);
            dec_acc = wide[13:0];
            held    = dec_held + SYM_BITS;
            if (held >= BYTE_BITS) begin
               dbyte   = dec_acc[7:0];
               got     = 1'b1;
               dec_acc = dec_acc >> 8;
               held    = held - BYTE_BITS;
               if (dec_count < COUNT_TOP) dec_count++;
            end
            dec_held = held;
         end
      end

      if (got || last) begin
         expected_out_q.push_back({dbyte, got, last, dec_err, dec_count[15:0]});
      end
      if (last) begin
         dec_acc   = '0;
         dec_held  = '0;
         dec_err   = 1'b0;
         dec_count = 0;
      end
   endtask

   // symbol index to its alphabet character
   function automatic logic [7:0] sym_char(input int idx);
      if (idx == 0) return CHAR_DOLLAR;
      if (idx <= 10) return CHAR_ZERO + 8'(idx - 1);
      if (idx <= 36) return CHAR_UPPER_A + 8'(idx - 11);
      if (idx == 37) return CHAR_UNDER;
      return CHAR_LOWER_A + 8'(idx - 38);
   endfunction

   task automatic push_item(input logic [7:0] code, input logic last);
      char_item_type it;
      it.code   = code;
      it.last   = last;
      it.steady = (calm_left > 0);
      it.gap    = (calm_left > 0) ? 0 : $urandom_range(0, 11);
      it.drain  = 1'b0;
      it.hold   = hold_next;
      hold_next = 1'b0;
      if (calm_left > 0) calm_left--;
      pending_q.push_back(it);
      items_queued++;
   endtask

   // one text of random content; kind 0 noise, 1 with a bad character, else clean
   task automatic push_text(input int len, input int kind);
      int         bad_pos;
      logic [7:0] code;
      bad_pos = $urandom_range(0, len - 1);
      for (int i = 0; i < len; i++) begin
         if (kind == 0) begin
            code = 8'($urandom_range(0, 255));
         end else if (kind == 1 && i == bad_pos) begin
            case ($urandom_range(0, 3))
               0: code = 8'($urandom_range(128, 255));
               1: code = "=";
               2: code = "+";
               default: code = 8'($urandom_range(0, 8));
            endcase
         end else if ($urandom_range(0, 15) == 0) begin
            case ($urandom_range(0, 3))
               0: code = CHAR_SPACE;
               1: code = CHAR_TAB;
               2: code = CHAR_CR;
               default: code = CHAR_LF;
            endcase
         end else begin
            code = sym_char($urandom_range(0, 63));
         end
         push_item(code, i == len - 1);
      end
   endtask

   // driver: offers queued characters, predicts each accepted one
   always @(posedge clock) begin
      logic          offering;
      char_item_type nxt_item;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tlast  <= 1'b0;
         send_gap = 0;
      end else begin
         offering = req_tvalid;
         if (req_tvalid && req_tready) begin
            decode_char(req_tdata, req_tlast);
            offering = 1'b0;
         end
         if (!offering && send_gap > 0) begin
            send_gap--;
         end else if (!offering && pending_q.size() > 0) begin
            if (pending_q[0].drain) begin
               // sender pause until all results are back
               if (expected_out_q.size() == 0) nxt_item = pending_q.pop_front();
            end else begin
               nxt_item = pending_q.pop_front();
               req_tdata <= nxt_item.code;
               req_tlast <= nxt_item.last;
               rx_steady <= nxt_item.steady;
               if (nxt_item.hold) hold_req <= 1'b1;
               send_gap = nxt_item.gap;
               offering = 1'b1;
            end
         end
         req_tvalid <= offering;
      end
   end

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (reset) begin
         rx_hold <= 1'b0;
         hold_cycles = 0;
      end else if (hold_req && hold_cycles < HOLD_LEN) begin
         hold_cycles++;
         rx_hold <= 1'b1;
      end else begin
         rx_hold <= 1'b0;
      end
   end

   // monitor: checks each accepted result against the oldest expectation
   always @(posedge clock) begin
      text_result_type seen;
      text_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen = {rsp_tdata[7:0], rsp_tuser, rsp_tlast, rsp_tdata[8], rsp_tdata[24:9]};
            if (expected_out_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result, expected none, actual byte %h valid %b",
                        $time, seen.data_byte, seen.byte_valid,
                        " end %b bad %b count %0d",
                        seen.end_of_text, seen.bad_char, seen.byte_count);
            end else begin
               want = expected_out_q.pop_front();
               if (seen !== want) begin
                  fail_count++;
                  $display("%0t: mismatch, expected byte %h valid %b end %b bad %b",
                           $time, want.data_byte, want.byte_valid, want.end_of_text,
                           want.bad_char, " count %0d, actual byte %h valid %b",
                           want.byte_count, seen.data_byte, seen.byte_valid,
                           " end %b bad %b count %0d",
                           seen.end_of_text, seen.bad_char, seen.byte_count);
               end
            end
            recv_wait = rx_steady ? 0 : $urandom_range(0, 11);
         end else if (recv_wait > 0) begin
            recv_wait--;
         end
         rsp_tready <= (recv_wait == 0) && !rx_hold;
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // stimulus and end of run
   initial begin
      bit hold_done;
      bit pause_done;
      int kind;
      int len;
      hold_done  = 1'b0;
      pause_done = 1'b0;

      // alphabet extremes and every blank, ending on a digit
      push_item("$", 1'b0);
      push_item("9", 1'b0);
      push_item("A", 1'b0);
      push_item("Z", 1'b0);
      push_item("_", 1'b0);
      push_item("a", 1'b0);
      push_item("z", 1'b0);
      push_item(CHAR_SPACE, 1'b0);
      push_item(CHAR_TAB, 1'b0);
      push_item(CHAR_CR, 1'b0);
      push_item(CHAR_LF, 1'b0);
      push_item("0", 1'b1);
      // blank as the only and last character
      push_item(CHAR_SPACE, 1'b1);
      // byte shares the closing item
      push_item("A", 1'b0);
      push_item("B", 1'b1);
      // bad character mid text, later ones ignored, invalid last
      push_item("Q", 1'b0);
      push_item("R", 1'b0);
      push_item("S", 1'b0);
      push_item("#", 1'b0);
      push_item("Q", 1'b0);
      push_item(8'h7F, 1'b0);
      push_item(8'hFF, 1'b0);
      push_item(8'h80, 1'b1);
      // bad character as the first and last
      push_item(8'h00, 1'b1);
      pending_q.push_back('{code: 8'h00, last: 1'b0, gap: 0, steady: 1'b0,
                            drain: 1'b1, hold: 1'b0});

      // random texts, mostly well formed
      while (items_queued < 1925) begin
         if ($urandom_range(0, 4) == 0) calm_left = $urandom_range(20, 80);
         if (!hold_done && items_queued > 700) begin
            hold_done = 1'b1;
            hold_next = 1'b1;
            calm_left = 100;
         end
         if (!pause_done && items_queued > 1200) begin
            pause_done = 1'b1;
            pending_q.push_back('{code: 8'h00, last: 1'b0, gap: 0, steady: 1'b0,
                                  drain: 1'b1, hold: 1'b0});
         end
         kind = $urandom_range(0, 9);
         len  = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                            : $urandom_range(1, 40);
         push_text(len, kind);
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending_q.size() > 0 || req_tvalid) @(posedge clock);
      while (expected_out_q.size() > 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
